// ===== hw/rtl/lru_block_tracker_top_defines.svh =====
// assertion macros shared by the tracker modules
`ifndef LRU_BLOCK_TRACKER_TOP_DEFINES_SVH
`define LRU_BLOCK_TRACKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LBT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LBT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LBT_ASSERT(lbl, clk, rst_n, prop, msg)
`define LBT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/lbt_pkg.sv =====
package lbt_pkg;

    localparam int BLOCKS = 1024;
    localparam int BLK_W  = $clog2(BLOCKS);
    localparam int CNT_W  = BLK_W + 1;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(BLOCKS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_LINK,
        S_FILL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic accept;
        logic eval;
        logic link;
        logic fill;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic hit;
        logic at_head;
        logic evict;
    } t_sts;

endpackage

// ===== hw/rtl/lbt_ctrl.sv =====
`include "lru_block_tracker_top_defines.svh"

module lbt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  lbt_pkg::t_sts i_sts,
    output lbt_pkg::t_cmd o_cmd
);
    import lbt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        cmd        = '0;
        n_state    = r_state;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                // a hit away from the head still has to be relinked at the head
                if (i_sts.hit && !i_sts.at_head) begin
                    n_state = S_LINK;
                end else if (i_sts.evict) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LINK: begin
                cmd.link = 1'b1;
                n_state  = S_DONE;
            end
            S_FILL: begin
                cmd.fill = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `LBT_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> r_state == S_CLEAR, "no clear pass after reset")
    `LBT_ASSERT(a_eval_after_accept, i_clk, i_rst_n, r_state == S_EVAL |-> $past(cmd.accept), "eval without transaction")
    `LBT_ASSERT(a_tail_work_after_eval, i_clk, i_rst_n, (r_state == S_LINK || r_state == S_FILL) |-> $past(r_state) == S_EVAL, "relink out of order")
    `LBT_ASSERT(a_emit_shows_result, i_clk, i_rst_n, cmd.emit |=> r_out_valid, "result lost after emit")

endmodule

// ===== hw/rtl/lbt_dpath.sv =====
`include "lru_block_tracker_top_defines.svh"

module lbt_dpath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lbt_pkg::t_cmd             i_cmd,
    output lbt_pkg::t_sts             o_sts,
    input  logic                      i_cfg_valid,
    input  logic [lbt_pkg::CNT_W-1:0] i_cfg_capacity,
    input  logic [lbt_pkg::BLK_W-1:0] i_block_number,
    output logic                      o_hit,
    output logic                      o_evicted,
    output logic [lbt_pkg::BLK_W-1:0] o_evicted_block,
    output logic [lbt_pkg::CNT_W-1:0] o_occupancy
);
    import lbt_pkg::*;

    logic             r_res_mem  [BLOCKS];
    logic [BLK_W-1:0] r_prev_mem [BLOCKS];
    logic [BLK_W-1:0] r_next_mem [BLOCKS];

    logic [CNT_W-1:0] r_capacity;
    logic [BLK_W-1:0] r_head;
    logic [BLK_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;
    logic [BLK_W-1:0] r_clr_addr;

    logic [BLK_W-1:0] r_bn;
    logic             r_res_rd;
    logic [BLK_W-1:0] r_prev_rd;
    logic [BLK_W-1:0] r_next_rd;
    logic             r_hit;
    logic             r_ev;
    logic [BLK_W-1:0] r_evb;
    logic             r_o_hit;
    logic             r_o_ev;
    logic [BLK_W-1:0] r_o_evb;
    logic [CNT_W-1:0] r_o_occ;

    logic             is_head;
    logic             is_tail;
    logic             evict;
    logic             count_one;
    logic             count_zero;
    logic             hit_mid;
    logic             link_head;

    logic             res_we;
    logic [BLK_W-1:0] res_wa;
    logic             res_wd;
    logic             prev_we;
    logic [BLK_W-1:0] prev_wa;
    logic [BLK_W-1:0] prev_wd;
    logic             prev_re;
    logic [BLK_W-1:0] prev_ra;
    logic             next_we;
    logic [BLK_W-1:0] next_wa;
    logic [BLK_W-1:0] next_wd;

    assign is_head    = r_bn == r_head;
    assign is_tail    = r_bn == r_tail;
    assign count_zero = r_count == '0;
    assign count_one  = r_count == CNT_W'(1);
    // a capacity of zero behaves as one: any non-empty cache is full
    assign evict      = !r_res_rd && !count_zero && (r_count >= r_capacity);
    assign hit_mid    = i_cmd.eval && r_res_rd && !is_head && !is_tail;
    // new head link: miss without eviction into a non-empty list, relink, or refill
    assign link_head  = (i_cmd.eval && !r_res_rd && !evict && !count_zero)
                      || i_cmd.link || (i_cmd.fill && !count_one);

    assign o_sts = '{clr_last: &r_clr_addr, hit: r_res_rd, at_head: is_head, evict: evict};

    always_comb begin
        res_we = 1'b0;
        res_wa = r_bn;
        res_wd = 1'b0;
        if (i_cmd.clr) begin
            res_we = 1'b1;
            res_wa = r_clr_addr;
        end else if (i_cmd.eval && !r_res_rd) begin
            res_we = 1'b1;
            if (evict) begin
                res_wa = r_tail;
            end else begin
                res_wd = 1'b1;
            end
        end else if (i_cmd.fill) begin
            res_we = 1'b1;
            res_wd = 1'b1;
        end
    end

    always_comb begin
        prev_we = 1'b0;
        prev_wa = r_head;
        prev_wd = r_bn;
        next_we = 1'b0;
        next_wa = r_bn;
        next_wd = r_head;
        if (hit_mid) begin
            // unlink from the middle of the list
            prev_we = 1'b1;
            prev_wa = r_next_rd;
            prev_wd = r_prev_rd;
            next_we = 1'b1;
            next_wa = r_prev_rd;
            next_wd = r_next_rd;
        end else if (link_head) begin
            prev_we = 1'b1;
            next_we = 1'b1;
        end
    end

    assign prev_re = i_cmd.accept || (i_cmd.eval && evict);
    assign prev_ra = i_cmd.accept ? i_block_number : r_tail;

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            r_res_mem[res_wa] <= res_wd;
        end
        if (i_cmd.accept) begin
            r_res_rd <= r_res_mem[i_block_number];
        end
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
        if (prev_re) begin
            r_prev_rd <= r_prev_mem[prev_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
        if (i_cmd.accept) begin
            r_next_rd <= r_next_mem[i_block_number];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_capacity;
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + BLK_W'(1);
            end
            if (i_cmd.eval) begin
                if (r_res_rd) begin
                    if (!is_head && is_tail) begin
                        r_tail <= r_prev_rd;
                    end
                end else if (!evict) begin
                    r_head  <= r_bn;
                    r_count <= r_count + CNT_W'(1);
                    if (count_zero) begin
                        r_tail <= r_bn;
                    end
                end
            end
            if (i_cmd.link) begin
                r_head <= r_bn;
            end
            // eviction plus insertion leaves the count where it was
            if (i_cmd.fill) begin
                r_head <= r_bn;
                r_tail <= count_one ? r_bn : r_prev_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_bn <= i_block_number;
        end
        if (i_cmd.eval) begin
            r_hit <= r_res_rd;
            r_ev  <= evict;
            r_evb <= evict ? r_tail : '0;
        end
        if (i_cmd.emit) begin
            r_o_hit <= r_hit;
            r_o_ev  <= r_ev;
            r_o_evb <= r_evb;
            r_o_occ <= r_count;
        end
    end

    assign o_hit           = r_o_hit;
    assign o_evicted       = r_o_ev;
    assign o_evicted_block = r_o_evb;
    assign o_occupancy     = r_o_occ;

    `LBT_ASSERT(a_fill_keeps_count, i_clk, i_rst_n, i_cmd.fill |=> r_count == $past(r_count), "occupancy moved on eviction")
    `LBT_ASSERT(a_emit_not_empty, i_clk, i_rst_n, i_cmd.emit |-> r_count != '0, "empty cache after access")

endmodule

// ===== hw/rtl/lru_block_tracker_top.sv =====
// flow: an input transaction is taken in S_IDLE and evaluated in S_EVAL; a hit
// away from the head passes S_LINK, a miss with eviction S_FILL, and any other
// access goes to S_DONE, which loads the output register once it is free, and only
// then is a new access taken. reset: synchronous active low; a clear pass clears
// every resident flag before the first input transaction, capacity resets to 1024

module lru_block_tracker_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [lbt_pkg::BLK_W-1:0] i_block_number,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_hit,
    output logic                      o_evicted,
    output logic [lbt_pkg::BLK_W-1:0] o_evicted_block,
    output logic [lbt_pkg::CNT_W-1:0] o_occupancy,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [lbt_pkg::CNT_W-1:0] i_cfg_capacity
);
    import lbt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    lbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lbt_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_capacity  (i_cfg_capacity),
        .i_block_number  (i_block_number),
        .o_hit           (o_hit),
        .o_evicted       (o_evicted),
        .o_evicted_block (o_evicted_block),
        .o_occupancy     (o_occupancy)
    );

endmodule

// ===== tb/testbench.sv =====
module testbench;

    import lbt_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [BLK_W-1:0] evicted_block;
        logic [CNT_W-1:0] occupancy;
    } t_access_outcome;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic [BLK_W-1:0] i_block_number = '0;
    logic             i_out_ready = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [CNT_W-1:0] i_cfg_capacity = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic             o_hit;
    logic             o_evicted;
    logic [BLK_W-1:0] o_evicted_block;
    logic [CNT_W-1:0] o_occupancy;
    logic             o_cfg_ready;

    // shadow of the recency list, next toward tail and next toward head
    logic [CNT_W-1:0] cap_setting = CAP_RESET;
    bit               is_resident [BLOCKS];
    logic [BLK_W-1:0] toward_tail [BLOCKS];
    logic [BLK_W-1:0] toward_head [BLOCKS];
    logic [BLK_W-1:0] head_blk = '0;
    logic [BLK_W-1:0] tail_blk = '0;
    int               live_count = 0;

    t_access_outcome  access_outcomes_q[$];

    int  fault_count = 0;
    int  accesses_sent = 0;
    int  outcomes_seen = 0;
    int  hits_seen = 0;
    int  evictions_seen = 0;
    int  cap_writes = 0;
    int  stall_cycles = 0;
    int  stall_request = 0;
    int  stall_left = 0;
    bit  calm_phase = 1'b0;

    lru_block_tracker_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_block_number  (i_block_number),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_hit           (o_hit),
        .o_evicted       (o_evicted),
        .o_evicted_block (o_evicted_block),
        .o_occupancy     (o_occupancy),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_capacity  (i_cfg_capacity)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void link_first(input logic [BLK_W-1:0] blk);
        toward_tail[blk] = head_blk;
        toward_head[head_blk] = blk;
        head_blk = blk;
    endfunction

    function automatic t_access_outcome predict_access(input logic [BLK_W-1:0] blk);
        t_access_outcome  r;
        int               eff_cap;
        logic [BLK_W-1:0] up;
        logic [BLK_W-1:0] down;
        logic [BLK_W-1:0] victim;
        r = '0;
        eff_cap = (cap_setting == '0) ? 1 : int'(cap_setting);
        if (is_resident[blk]) begin
            r.hit = 1'b1;
            if (blk != head_blk) begin
                up = toward_head[blk];
                if (blk == tail_blk) begin
                    tail_blk = up;
                end else begin
                    down = toward_tail[blk];
                    toward_tail[up] = down;
                    toward_head[down] = up;
                end
                link_first(blk);
            end
        end else begin
            if (live_count > 0 && live_count >= eff_cap) begin
                victim = tail_blk;
                r.evicted = 1'b1;
                r.evicted_block = victim;
                is_resident[victim] = 1'b0;
                // a lone resident block leaves the list empty
                if (live_count == 1) begin
                    live_count = 0;
                end else begin
                    tail_blk = toward_head[victim];
                    live_count--;
                end
            end
            is_resident[blk] = 1'b1;
            if (live_count == 0) begin
                head_blk = blk;
                tail_blk = blk;
            end else begin
                link_first(blk);
            end
            live_count++;
        end
        r.occupancy = CNT_W'(live_count);
        return r;
    endfunction

    // mostly a block that is not resident yet, so the cache keeps filling
    function automatic logic [BLK_W-1:0] pick_block(input int fresh_pct);
        logic [BLK_W-1:0] blk;
        blk = BLK_W'($urandom);
        if ($urandom_range(99) < fresh_pct && live_count < BLOCKS) begin
            while (is_resident[blk]) blk = blk + 1'b1;
        end
        return blk;
    endfunction

    task automatic send_access(input logic [BLK_W-1:0] blk);
        while (!calm_phase && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_block_number <= blk;
        do @(posedge i_clk); while (!o_in_ready);
        access_outcomes_q.push_back(predict_access(blk));
        accesses_sent++;
    endtask

    task automatic wait_for_outcomes();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (access_outcomes_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        wait_for_outcomes();
        i_cfg_valid <= 1'b1;
        i_cfg_capacity <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_setting = cap;
        cap_writes++;
    endtask

    // capacity zero acts as one; the first eviction empties the list
    task automatic test_single_entry();
        write_capacity('0);
        send_access('0);
        send_access('1);
        send_access('1);
        send_access(BLK_W'(7));
    endtask

    // hits at the tail and at the head, then a tail eviction
    task automatic test_list_reorder();
        write_capacity(CNT_W'(3));
        send_access(BLK_W'(8));
        send_access(BLK_W'(9));
        send_access(BLK_W'(8));
        send_access(BLK_W'(7));
        send_access(BLK_W'(7));
        send_access(BLK_W'(10));
    endtask

    task automatic test_capacity_extremes();
        write_capacity('1);
        send_access(BLK_W'(512));
        send_access(BLK_W'(1));
        // capacity now below occupancy, so every miss swaps one block
        write_capacity(CNT_W'(1));
        send_access(BLK_W'(2));
        send_access('1);
        send_access(BLK_W'(512));
        write_capacity(CAP_RESET);
        send_access(BLK_W'(3));
    endtask

    task automatic test_random_phases(input int items);
        int               done;
        int               len;
        int               pick;
        int               ws_size;
        int               cap;
        logic [BLK_W-1:0] ws_base;
        done = 0;
        while (done < items) begin
            pick = $urandom_range(99);
            len = $urandom_range(20, 60);
            if (pick < 10) cap = 0;
            else if (pick < 20) cap = 1;
            else if (pick < 30) cap = 2;
            else if (pick < 55) cap = $urandom_range(3, 16);
            else if (pick < 80) cap = live_count + $urandom_range(0, 4);
            else if (pick < 90) cap = $urandom_range(17, 64);
            else begin
                cap = $urandom_range(BLOCKS + 1, 2047);
                len = $urandom_range(10, 20);
            end
            if (cap > 2047) cap = 2047;
            write_capacity(CNT_W'(cap));
            ws_base = BLK_W'($urandom);
            ws_size = $urandom_range(1, 24);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(99) < 85)
                    send_access(ws_base + BLK_W'($urandom_range(0, ws_size - 1)));
                else
                    send_access(BLK_W'($urandom));
            end
            done += len;
        end
    endtask

    task automatic test_no_idle_stretch();
        calm_phase = 1'b1;
        test_random_phases(150);
        wait_for_outcomes();
        calm_phase = 1'b0;
    endtask

    // receiver holds off while transactions keep coming, so the input stalls
    task automatic test_output_backpressure();
        logic [BLK_W-1:0] ws_base;
        write_capacity(CNT_W'(6));
        ws_base = BLK_W'($urandom);
        stall_request = HOLD_CYCLES;
        for (int k = 0; k < 30; k++)
            send_access(ws_base + BLK_W'($urandom_range(0, 9)));
        wait_for_outcomes();
    endtask

    task automatic test_drain_pause();
        for (int k = 0; k < 10; k++) send_access(BLK_W'($urandom_range(0, 31)));
        wait_for_outcomes();
        for (int k = 0; k < 10; k++) send_access(BLK_W'($urandom_range(0, 31)));
    endtask

    // fill to one below full and evict there, then fill completely
    task automatic test_fill_cache();
        write_capacity(CNT_W'(BLOCKS - 1));
        while (live_count < BLOCKS - 1) send_access(pick_block(80));
        for (int k = 0; k < 12; k++) send_access(pick_block(100));
        write_capacity(CAP_RESET);
        while (live_count < BLOCKS) send_access(pick_block(80));
        for (int k = 0; k < 40; k++) send_access(BLK_W'($urandom));
    endtask

    always @(posedge i_clk) begin
        if (stall_request != 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (calm_phase) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 24);
        end
    end

    always @(posedge i_clk) begin
        t_access_outcome got;
        t_access_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_hit, o_evicted, o_evicted_block, o_occupancy};
            outcomes_seen++;
            if (got.hit) hits_seen++;
            if (got.evicted) evictions_seen++;
            if (access_outcomes_q.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result transaction: hit %0d evicted %0d blk %0d occ %0d",
                             got.hit, got.evicted, got.evicted_block, got.occupancy);
            end else begin
                want = access_outcomes_q.pop_front();
                if (got !== want) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: hit %0d/%0d evicted %0d/%0d blk %0d/%0d occ %0d/%0d (exp/act)",
                                 want.hit, got.hit, want.evicted, got.evicted,
                                 want.evicted_block, got.evicted_block,
                                 want.occupancy, got.occupancy);
                end
            end
        end
    end

    // cycles without any transaction on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d idle cycles", stall_cycles);
                $display("lru_block_tracker_top test failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_entry();
        test_list_reorder();
        test_capacity_extremes();
        test_random_phases(350);
        test_no_idle_stretch();
        test_output_backpressure();
        test_random_phases(200);
        test_drain_pause();
        test_fill_cache();
        wait_for_outcomes();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (access_outcomes_q.size() != 0) fault_count++;
        $display("%0d accesses, %0d results, %0d hits, %0d evictions, %0d capacity writes",
                 accesses_sent, outcomes_seen, hits_seen, evictions_seen, cap_writes);
        $display("final occupancy %0d, %0d faults", live_count, fault_count);
        if (fault_count == 0) begin
            $display("lru_block_tracker_top test passed");
        end else begin
            $display("lru_block_tracker_top test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lbt_pkg.sv
hw/rtl/lbt_ctrl.sv
hw/rtl/lbt_dpath.sv
hw/rtl/lru_block_tracker_top.sv
tb/testbench.sv
